// ===== rtl/trwq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamped register-write queue package
// Shared constants, operation codes, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package trwq_pkg;

   // Ring geometry. One slot is always kept spare.
   localparam int QUEUE_DEPTH = 4096;
   localparam int INDEX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(QUEUE_DEPTH - 1);

   // Field widths.
   localparam int TIME_WIDTH = 32;
   localparam int BYTE_WIDTH = 8;

   // An entry is due when the elapsed time is below half the clock range.
   localparam logic [TIME_WIDTH-1:0] DUE_LIMIT = 32'h8000_0000;

   // Command codes of an input word.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_PUSH  = 2'd1,
      OP_DRAIN = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // One stored event.
   typedef struct packed {
      logic [TIME_WIDTH-1:0] stamp;
      logic [BYTE_WIDTH-1:0] chip;
      logic [BYTE_WIDTH-1:0] register_address;
      logic [BYTE_WIDTH-1:0] value;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic tick;
      logic push;
      logic drain;
      logic clear;
      logic respond;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   due;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/trwq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module trwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

// ===== rtl/trwq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Queue controller
// Takes a command word when idle, then executes it in the execute state and
// tells the datapath which update to apply.
// ----------------------------------------------------------------------------
module trwq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  trwq_pkg::dp_status_type status,
   output trwq_pkg::ctrl_cmd_type  cmd
);
   import trwq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: every word passes through the execute state and returns to idle.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: decode the held command against the ring status.
   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.respond = 1'b1;
            case (status.op)
               OP_TICK:  cmd.tick  = 1'b1;
               OP_PUSH:  cmd.push  = !status.full;
               OP_DRAIN: cmd.drain = !status.empty && status.due;
               OP_CLEAR: cmd.clear = 1'b1;
               default:  cmd.tick  = 1'b0;
            endcase
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/trwq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Queue datapath
// Holds the microsecond clock, the ring indices, the event memory and the
// result registers, and applies the updates that the controller selects.
// ----------------------------------------------------------------------------
module trwq_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  trwq_pkg::ctrl_cmd_type  cmd,
   output trwq_pkg::dp_status_type status,
   input  logic [1:0]             req_command,
   input  logic [31:0]            req_time_value,
   input  logic [7:0]             req_chip_select,
   input  logic [7:0]             req_register_address,
   input  logic [7:0]             req_write_value,
   output logic                   rsp_valid,
   output logic                   rsp_push_accepted,
   output logic                   rsp_entry_valid,
   output logic [7:0]             rsp_out_chip,
   output logic [7:0]             rsp_out_register,
   output logic [7:0]             rsp_out_value,
   output logic [31:0]            rsp_current_time
);
   import trwq_pkg::*;

   // Captured word.
   op_type                op_ff;
   logic [TIME_WIDTH-1:0] time_ff;
   logic [BYTE_WIDTH-1:0] chip_ff;
   logic [BYTE_WIDTH-1:0] reg_ff;
   logic [BYTE_WIDTH-1:0] val_ff;

   // Queue state.
   logic [INDEX_WIDTH-1:0] write_index_ff, write_index_in;
   logic [INDEX_WIDTH-1:0] read_index_ff, read_index_in;
   logic [TIME_WIDTH-1:0]  clock_us_ff, clock_us_in;
   logic [INDEX_WIDTH-1:0] write_next;
   logic [INDEX_WIDTH-1:0] read_next;

   // Result registers.
   logic                  rsp_valid_ff;
   logic                  accepted_ff;
   logic                  entry_valid_ff;
   logic [BYTE_WIDTH-1:0] chip_out_ff, chip_out_in;
   logic [BYTE_WIDTH-1:0] reg_out_ff, reg_out_in;
   logic [BYTE_WIDTH-1:0] val_out_ff, val_out_in;
   logic [TIME_WIDTH-1:0] time_out_ff;

   // Memory interface.
   entry_type             write_entry;
   entry_type             read_entry;
   logic [ENTRY_WIDTH-1:0] read_bits;
   logic [TIME_WIDTH-1:0] elapsed;

   // Capture the word on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_command);
         time_ff <= req_time_value;
         chip_ff <= req_chip_select;
         reg_ff  <= req_register_address;
         val_ff  <= req_write_value;
      end
   end

   // Ring index successors, wrapping after the last slot.
   assign write_next = (write_index_ff == LAST_INDEX) ? '0 : write_index_ff + 1'b1;
   assign read_next  = (read_index_ff == LAST_INDEX) ? '0 : read_index_ff + 1'b1;

   // Event memory. The oldest slot is read every cycle, so its data is
   // ready in the execute cycle.
   assign write_entry = '{stamp: clock_us_ff, chip: chip_ff,
                          register_address: reg_ff, value: val_ff};

   trwq_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock         (clock),
      .write_enable  (cmd.push),
      .write_address (write_index_ff),
      .write_data    (write_entry),
      .read_address  (read_index_ff),
      .read_data     (read_bits)
   );

   assign read_entry = entry_type'(read_bits);

   // Ring status for the controller.
   assign elapsed      = time_ff - read_entry.stamp;
   assign status.op    = op_ff;
   assign status.full  = (write_next == read_index_ff);
   assign status.empty = (read_index_ff == write_index_ff);
   assign status.due   = (elapsed < DUE_LIMIT);

   // Next queue state.
   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      clock_us_in    = clock_us_ff;
      if (cmd.tick) begin
         clock_us_in = clock_us_ff + time_ff;
      end
      if (cmd.push) begin
         write_index_in = write_next;
      end
      if (cmd.drain) begin
         read_index_in = read_next;
      end
      if (cmd.clear) begin
         write_index_in = '0;
         read_index_in  = '0;
         clock_us_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         read_index_ff  <= '0;
         clock_us_ff    <= '0;
      end else begin
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         clock_us_ff    <= clock_us_in;
      end
   end

   // Released fields read as zero unless an entry leaves the ring.
   always_comb begin
      chip_out_in = '0;
      reg_out_in  = '0;
      val_out_in  = '0;
      if (cmd.drain) begin
         chip_out_in = read_entry.chip;
         reg_out_in  = read_entry.register_address;
         val_out_in  = read_entry.value;
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         accepted_ff    <= cmd.push;
         entry_valid_ff <= cmd.drain;
         chip_out_ff    <= chip_out_in;
         reg_out_ff     <= reg_out_in;
         val_out_ff     <= val_out_in;
         time_out_ff    <= clock_us_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_push_accepted = accepted_ff;
   assign rsp_entry_valid   = entry_valid_ff;
   assign rsp_out_chip      = chip_out_ff;
   assign rsp_out_register  = reg_out_ff;
   assign rsp_out_value     = val_out_ff;
   assign rsp_current_time  = time_out_ff;

endmodule
`default_nettype wire

// ===== rtl/timestamped_register_write_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamped register-write queue
// A ring of time-stamped register writes with a microsecond clock; tick,
// push, drain-one-due-entry and reset commands.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Busy is then
// high for one cycle while the word executes, and the result appears on the
// rsp_ ports for exactly one cycle, marked by rsp_valid, registered at the end
// of the execute state; the receiver cannot stall it. A new word can be taken
// as soon as busy falls, including in the cycle the previous result is shown.
// The execute state is needed because of the registered read port of the event
// memory, whose oldest slot must be read before a drain can decide. The ring
// holds at most 4095 entries and needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module timestamped_register_write_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_time_value,
   input  logic [7:0]  req_chip_select,
   input  logic [7:0]  req_register_address,
   input  logic [7:0]  req_write_value,
   output logic        rsp_valid,
   output logic        rsp_push_accepted,
   output logic        rsp_entry_valid,
   output logic [7:0]  rsp_out_chip,
   output logic [7:0]  rsp_out_register,
   output logic [7:0]  rsp_out_value,
   output logic [31:0] rsp_current_time
);
   import trwq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing.
   trwq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Clock, ring and results.
   trwq_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_command          (req_command),
      .req_time_value       (req_time_value),
      .req_chip_select      (req_chip_select),
      .req_register_address (req_register_address),
      .req_write_value      (req_write_value),
      .rsp_valid            (rsp_valid),
      .rsp_push_accepted    (rsp_push_accepted),
      .rsp_entry_valid      (rsp_entry_valid),
      .rsp_out_chip         (rsp_out_chip),
      .rsp_out_register     (rsp_out_register),
      .rsp_out_value        (rsp_out_value),
      .rsp_current_time     (rsp_current_time)
   );

endmodule
`default_nettype wire

// ===== rtl/trwq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Queue port checker
// Watches the top-level ports for timing and result consistency.
// ----------------------------------------------------------------------------
module trwq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_push_accepted,
   input logic        rsp_entry_valid,
   input logic [7:0]  rsp_out_chip,
   input logic [7:0]  rsp_out_register,
   input logic [7:0]  rsp_out_value,
   input logic [31:0] rsp_current_time
);
   import trwq_pkg::*;

   // An accepted word holds the block busy for exactly one cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 !busy)
      else $error("busy did not span exactly one cycle after a word");

   // Every result traces back to an accepted word.
   a_result_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching word");

   // A push result never releases an entry.
   a_push_or_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_push_accepted && rsp_entry_valid))
      else $error("push and drain reported together");

   // Released fields are zero when no entry leaves the ring.
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |->
         (rsp_out_chip == 8'd0 && rsp_out_register == 8'd0 && rsp_out_value == 8'd0))
      else $error("released fields not zero without a released entry");

   // A reset command returns the clock to zero.
   a_clear_zeroes_time: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == OP_CLEAR) |=> ##1
         (rsp_valid && rsp_current_time == 32'd0))
      else $error("clock not zero after a reset command");

endmodule

bind timestamped_register_write_queue_top trwq_checker u_trwq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_push_accepted (rsp_push_accepted),
   .rsp_entry_valid   (rsp_entry_valid),
   .rsp_out_chip      (rsp_out_chip),
   .rsp_out_register  (rsp_out_register),
   .rsp_out_value     (rsp_out_value),
   .rsp_current_time  (rsp_current_time)
);
`default_nettype wire
